FILE: src/matrix4x4_float_multiply_macros.svh
// Assertion macros used by the matrix multiply top level.
`ifndef MATRIX4X4_FLOAT_MULTIPLY_MACROS_SVH
`define MATRIX4X4_FLOAT_MULTIPLY_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define MX4_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define MX4_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define MX4_ASSERT_IMP(lbl, ante, cons)
`define MX4_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: src/mx4_pkg.sv
// Package with binary32 helper types and arithmetic functions for the matrix multiply.
package mx4_pkg;

	localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
	localparam logic [31:0] FP_QUIET_BIT   = 32'h0040_0000;
	localparam logic [7:0]  FP_EXP_MAX     = 8'd255;
	localparam int          RND_BITS       = 39;
	localparam logic [RND_BITS-1:0] RND_HALF = {1'b1, {(RND_BITS-1){1'b0}}};

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_MUL  = 1'b1;

	// Unrounded result: either a resolved special value or sign, exponent and
	// significand scaled so that the value is sig / 2^62 * 2^(exp - 127).
	typedef struct packed {
		logic                special;
		logic [31:0]         spec_val;
		logic                sgn;
		logic signed [10:0]  exp;
		logic [63:0]         sig;
	} fpraw_t;

	function automatic logic is_nan(logic [31:0] x);
		return (x[30:23] == FP_EXP_MAX) && (x[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(logic [31:0] x);
		return (x[30:23] == FP_EXP_MAX) && (x[22:0] == 23'd0);
	endfunction

	function automatic logic is_zero(logic [31:0] x);
		return x[30:0] == 31'd0;
	endfunction

	// Subnormals use exponent one and no hidden bit.
	function automatic logic [7:0] unp_exp(logic [31:0] x);
		return (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
	endfunction

	function automatic logic [23:0] unp_man(logic [31:0] x);
		return {(x[30:23] != 8'd0), x[22:0]};
	endfunction

	// Right shift that ORs every bit shifted out into the lowest bit.
	function automatic logic [63:0] shr_sticky(logic [63:0] x, logic [10:0] n);
		logic [63:0] lost;
		lost = x & ((64'd1 << n[5:0]) - 64'd1);
		if (n == 11'd0)
			return x;
		else if (n >= 11'd63)
			return {63'd0, |x};
		else
			return (x >> n[5:0]) | {63'd0, |lost};
	endfunction

	// Front half of a multiply: special cases and the significand product.
	function automatic fpraw_t fp_mul_front(logic [31:0] a, logic [31:0] b);
		fpraw_t r;
		logic s;
		logic [47:0] prod;
		r = '0;
		s = a[31] ^ b[31];
		r.sgn = s;
		prod = unp_man(a) * unp_man(b);
		if (is_nan(a)) begin
			r.special = 1'b1;
			r.spec_val = a | FP_QUIET_BIT;
		end else if (is_nan(b)) begin
			r.special = 1'b1;
			r.spec_val = b | FP_QUIET_BIT;
		end else if (is_inf(a) || is_inf(b)) begin
			r.special = 1'b1;
			r.spec_val = (is_zero(a) || is_zero(b)) ? FP_DEFAULT_NAN : {s, FP_EXP_MAX, 23'd0};
		end else if (is_zero(a) || is_zero(b)) begin
			r.special = 1'b1;
			r.spec_val = {s, 31'd0};
		end else begin
			r.exp = $signed({3'd0, unp_exp(a)}) + $signed({3'd0, unp_exp(b)}) - 11'sd127;
			r.sig = {prod, 16'd0};
		end
		return r;
	endfunction

	// Front half of an add: special cases, operand swap, alignment and add.
	function automatic fpraw_t fp_add_front(logic [31:0] a, logic [31:0] b);
		fpraw_t r;
		logic sa, sb, st;
		logic [7:0] ea, eb, et;
		logic [23:0] ma, mb, mt;
		logic [63:0] xa, xb;
		r = '0;
		sa = a[31];
		sb = b[31];
		ea = unp_exp(a);
		eb = unp_exp(b);
		ma = unp_man(a);
		mb = unp_man(b);
		if ((ea < eb) || ((ea == eb) && (ma < mb))) begin
			et = ea; ea = eb; eb = et;
			mt = ma; ma = mb; mb = mt;
			st = sa; sa = sb; sb = st;
		end
		xa = {1'b0, ma, {RND_BITS{1'b0}}};
		xb = shr_sticky({1'b0, mb, {RND_BITS{1'b0}}}, {3'd0, ea - eb});
		if (is_nan(a)) begin
			r.special = 1'b1;
			r.spec_val = a | FP_QUIET_BIT;
		end else if (is_nan(b)) begin
			r.special = 1'b1;
			r.spec_val = b | FP_QUIET_BIT;
		end else if (is_inf(a)) begin
			r.special = 1'b1;
			r.spec_val = (is_inf(b) && (a[31] != b[31])) ? FP_DEFAULT_NAN : a;
		end else if (is_inf(b)) begin
			r.special = 1'b1;
			r.spec_val = b;
		end else if (is_zero(a) && is_zero(b)) begin
			r.special = 1'b1;
			r.spec_val = {a[31] & b[31], 31'd0};
		end else if (is_zero(a)) begin
			r.special = 1'b1;
			r.spec_val = b;
		end else if (is_zero(b)) begin
			r.special = 1'b1;
			r.spec_val = a;
		end else begin
			r.sgn = sa;
			r.exp = $signed({3'd0, ea});
			r.sig = (sa == sb) ? (xa + xb) : (xa - xb);
		end
		return r;
	endfunction

	// Back half shared by multiply and add: normalize, round to nearest even, pack.
	function automatic logic [31:0] fp_round(fpraw_t r);
		logic [63:0] sig;
		logic signed [10:0] e;
		logic signed [10:0] em1;
		logic [5:0] lz;
		logic [24:0] m;
		logic [RND_BITS-1:0] rem;
		logic up;
		logic [31:0] res;
		sig = r.sig;
		e = r.exp;
		lz = 6'd0;
		res = 32'd0;
		if (sig[63]) begin
			sig = {1'b0, sig[63:1]} | {63'd0, sig[0]};
			e = e + 11'sd1;
		end
		for (int i = 0; i < 63; i++) begin
			if (sig[i])
				lz = 6'(62 - i);
		end
		sig = sig << lz;
		e = e - $signed({5'd0, lz});
		if (e >= 11'sd255) begin
			res = {r.sgn, FP_EXP_MAX, 23'd0};
		end else begin
			if (e <= 11'sd0) begin
				sig = shr_sticky(sig, 11'(11'sd1 - e));
				e = 11'sd1;
			end
			em1 = e - 11'sd1;
			m = {1'b0, sig[62:RND_BITS]};
			rem = sig[RND_BITS-1:0];
			up = (rem > RND_HALF) || ((rem == RND_HALF) && m[0]);
			m = m + {24'd0, up};
			res = {r.sgn, 31'd0} + {1'b0, em1[7:0], 23'd0} + {7'd0, m};
		end
		if (r.special)
			return r.spec_val;
		else if (r.sig == 64'd0)
			return 32'd0;
		else
			return res;
	endfunction

endpackage

FILE: src/matrix4x4_float_multiply.sv
// Top level of the pipelined 4x4 binary32 matrix multiply.
//
// Input channel (in_valid/in_ready): each transaction carries req_type, row_index and
// four binary32 elements. A load transaction (req_type 0) writes one row of the right
// matrix B and produces nothing. A multiply transaction (req_type 1) carries one row of
// the left matrix A and produces the matching row of A*B on the output channel
// (out_valid/out_ready), with out_row copied from row_index.
// Four column lanes run side by side; each multiplies, rounds and sums in the order
// ((a0*b0j + a1*b1j) + a2*b2j) + a3*b3j with round to nearest even.
// One transaction is taken every cycle while the output is taken; a multiply right
// after a load sees the new row. When the receiver stalls with a result waiting, the
// whole eight-stage pipeline holds and in_ready drops until the result is taken.
// Reset clears the pipeline valid bits only; B rows must be loaded before use.
module matrix4x4_float_multiply
	import mx4_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic         req_type,
	input  logic [1:0]   row_index,
	input  logic [31:0]  elem0,
	input  logic [31:0]  elem1,
	input  logic [31:0]  elem2,
	input  logic [31:0]  elem3,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [1:0]   out_row,
	output logic [31:0]  out0,
	output logic [31:0]  out1,
	output logic [31:0]  out2,
	output logic [31:0]  out3
);

`include "matrix4x4_float_multiply_macros.svh"

	localparam int DEPTH = 8;

	logic [31:0] bmat_q [16];
	logic [DEPTH-1:0] valid_s;
	logic [1:0] row_s [DEPTH];
	logic [31:0] lane_res [4];
	logic adv;
	logic acc;

	// The pipeline moves whenever the final stage is empty or being drained.
	assign adv      = !valid_s[DEPTH-1] || out_ready;
	assign in_ready = adv;
	assign acc      = in_valid && adv;

	// Right matrix store, written by load transactions.
	always_ff @(posedge clk) begin
		if (acc && (req_type == REQ_LOAD)) begin
			bmat_q[{row_index, 2'd0}] <= elem0;
			bmat_q[{row_index, 2'd1}] <= elem1;
			bmat_q[{row_index, 2'd2}] <= elem2;
			bmat_q[{row_index, 2'd3}] <= elem3;
		end
	end

	// Valid bits follow multiply transactions through the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (adv) begin
			valid_s <= {valid_s[DEPTH-2:0], in_valid && (req_type == REQ_MUL)};
		end
	end

	// Row index travels beside the data.
	always_ff @(posedge clk) begin
		if (adv) begin
			row_s[0] <= row_index;
			for (int i = 1; i < DEPTH; i++)
				row_s[i] <= row_s[i-1];
		end
	end

	// One lane per output column.
	for (genvar j = 0; j < 4; j++) begin : g_lane
		mx4_lane u_lane (
			.clk(clk), .en(adv),
			.a0(elem0), .a1(elem1), .a2(elem2), .a3(elem3),
			.b0(bmat_q[j]), .b1(bmat_q[4 + j]), .b2(bmat_q[8 + j]), .b3(bmat_q[12 + j]),
			.res(lane_res[j])
		);
	end

	// Merge the lane results into the output transaction.
	assign out_valid = valid_s[DEPTH-1];
	assign out_row   = row_s[DEPTH-1];
	assign out0      = lane_res[0];
	assign out1      = lane_res[1];
	assign out2      = lane_res[2];
	assign out3      = lane_res[3];

	`MX4_ASSERT_NXT(a_mul_enters, acc && (req_type == REQ_MUL), valid_s[0])
	`MX4_ASSERT_NXT(a_load_no_entry, acc && (req_type == REQ_LOAD), !valid_s[0])
	`MX4_ASSERT_NXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(out0) && $stable(out_row))
	`MX4_ASSERT_IMP(a_ready_only_stall, !in_ready, out_valid && !out_ready)

endmodule

FILE: src/mx4_fmul.sv
// Multiplier front stage: special cases and significand product, registered.
module mx4_fmul
	import mx4_pkg::*;
(
	input  logic         clk,
	input  logic         en,
	input  logic [31:0]  a,
	input  logic [31:0]  b,
	output fpraw_t       raw
);

	fpraw_t raw_s1;

	// Register the unrounded product when the pipeline advances.
	always_ff @(posedge clk) begin
		if (en)
			raw_s1 <= fp_mul_front(a, b);
	end

	assign raw = raw_s1;

endmodule

FILE: src/mx4_fadd.sv
// Adder front stage: special cases, alignment and add, registered.
module mx4_fadd
	import mx4_pkg::*;
(
	input  logic         clk,
	input  logic         en,
	input  logic [31:0]  a,
	input  logic [31:0]  b,
	output fpraw_t       raw
);

	fpraw_t raw_s1;

	// Register the unrounded sum when the pipeline advances.
	always_ff @(posedge clk) begin
		if (en)
			raw_s1 <= fp_add_front(a, b);
	end

	assign raw = raw_s1;

endmodule

FILE: src/mx4_round.sv
// Rounding stage: normalizes, rounds and packs an unrounded result, registered.
module mx4_round
	import mx4_pkg::*;
(
	input  logic         clk,
	input  logic         en,
	input  fpraw_t       raw,
	output logic [31:0]  res
);

	logic [31:0] res_s1;

	// Register the packed binary32 value when the pipeline advances.
	always_ff @(posedge clk) begin
		if (en)
			res_s1 <= fp_round(raw);
	end

	assign res = res_s1;

endmodule

FILE: src/mx4_lane.sv
// One output column: four products and a chain of three adds, eight stages deep.
module mx4_lane
	import mx4_pkg::*;
(
	input  logic         clk,
	input  logic         en,
	input  logic [31:0]  a0,
	input  logic [31:0]  a1,
	input  logic [31:0]  a2,
	input  logic [31:0]  a3,
	input  logic [31:0]  b0,
	input  logic [31:0]  b1,
	input  logic [31:0]  b2,
	input  logic [31:0]  b3,
	output logic [31:0]  res
);

	fpraw_t      mraw [4];
	logic [31:0] prod [4];
	fpraw_t      araw [3];
	logic [31:0] sum  [3];
	logic [31:0] p2_s3, p2_s4;
	logic [31:0] p3_s3, p3_s4, p3_s5, p3_s6;

	// Products, rounded separately.
	mx4_fmul u_mul0 (.clk(clk), .en(en), .a(a0), .b(b0), .raw(mraw[0]));
	mx4_fmul u_mul1 (.clk(clk), .en(en), .a(a1), .b(b1), .raw(mraw[1]));
	mx4_fmul u_mul2 (.clk(clk), .en(en), .a(a2), .b(b2), .raw(mraw[2]));
	mx4_fmul u_mul3 (.clk(clk), .en(en), .a(a3), .b(b3), .raw(mraw[3]));

	for (genvar k = 0; k < 4; k++) begin : g_prnd
		mx4_round u_rnd (.clk(clk), .en(en), .raw(mraw[k]), .res(prod[k]));
	end

	// Later products wait until the running sum reaches them.
	always_ff @(posedge clk) begin
		if (en) begin
			p2_s3 <= prod[2];
			p2_s4 <= p2_s3;
			p3_s3 <= prod[3];
			p3_s4 <= p3_s3;
			p3_s5 <= p3_s4;
			p3_s6 <= p3_s5;
		end
	end

	// Accumulation in the fixed order ((p0 + p1) + p2) + p3.
	mx4_fadd u_add0 (.clk(clk), .en(en), .a(prod[0]), .b(prod[1]), .raw(araw[0]));
	mx4_round u_ar0 (.clk(clk), .en(en), .raw(araw[0]), .res(sum[0]));
	mx4_fadd u_add1 (.clk(clk), .en(en), .a(sum[0]), .b(p2_s4), .raw(araw[1]));
	mx4_round u_ar1 (.clk(clk), .en(en), .raw(araw[1]), .res(sum[1]));
	mx4_fadd u_add2 (.clk(clk), .en(en), .a(sum[1]), .b(p3_s6), .raw(araw[2]));
	mx4_round u_ar2 (.clk(clk), .en(en), .raw(araw[2]), .res(sum[2]));

	assign res = sum[2];

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the 4x4 binary32 matrix multiply.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mx4_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        req_type;
	logic [1:0]  row_index;
	logic [31:0] elem0, elem1, elem2, elem3;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  out_row;
	logic [31:0] out0, out1, out2, out3;

	// Receiver behavior, set by the stimulus process.
	int unsigned stall_pct;
	int unsigned hold_left;

	// Expected product row.
	typedef struct {
		logic [1:0]  row;
		logic [31:0] col [4];
	} prod_row_t;

	// Binary32 arithmetic that mirrors the block: separate rounding per step.
	function automatic bit f32_nan(bit [31:0] x);
		return x[30:23] == 8'hFF && x[22:0] != 0;
	endfunction

	function automatic bit f32_inf(bit [31:0] x);
		return x[30:0] == 31'h7F80_0000;
	endfunction

	function automatic bit f32_zero(bit [31:0] x);
		return x[30:0] == 0;
	endfunction

	function automatic longint unsigned sticky_shr(longint unsigned x, int n);
		if (n == 0)
			return x;
		if (n >= 63)
			return longint'(x != 0);
		return (x >> n) | longint'((x << (64 - n)) != 0);
	endfunction

	// Value is sig / 2^62 * 2^(e - 127).
	function automatic bit [31:0] pack_rounded(bit s, int e, longint unsigned sig);
		longint unsigned m, rem, half;
		if (sig[63]) begin
			sig = (sig >> 1) | (sig & 1);
			e++;
		end
		while (!sig[62]) begin
			sig = sig << 1;
			e--;
		end
		if (e >= 255)
			return {s, 8'hFF, 23'd0};
		if (e <= 0) begin
			sig = sticky_shr(sig, 1 - e);
			e = 1;
		end
		m = sig >> 39;
		rem = sig & ((64'd1 << 39) - 1);
		half = 64'd1 << 38;
		if (rem > half || (rem == half && m[0]))
			m++;
		return {s, 31'd0} + (32'(e - 1) << 23) + 32'(m);
	endfunction

	function automatic int exp_of(bit [31:0] x);
		return (x[30:23] == 0) ? 1 : int'(x[30:23]);
	endfunction

	function automatic longint unsigned man_of(bit [31:0] x);
		return {40'd0, x[30:23] != 0, x[22:0]};
	endfunction

	function automatic bit [31:0] f32_mul(bit [31:0] a, bit [31:0] b);
		bit s;
		s = a[31] ^ b[31];
		if (f32_nan(a))
			return a | 32'h0040_0000;
		if (f32_nan(b))
			return b | 32'h0040_0000;
		if (f32_inf(a) || f32_inf(b))
			return (f32_zero(a) || f32_zero(b)) ? FP_DEFAULT_NAN : {s, 8'hFF, 23'd0};
		if (f32_zero(a) || f32_zero(b))
			return {s, 31'd0};
		return pack_rounded(s, exp_of(a) + exp_of(b) - 127, (man_of(a) * man_of(b)) << 16);
	endfunction

	function automatic bit [31:0] f32_add(bit [31:0] a, bit [31:0] b);
		bit sa, sb, st;
		int ea, eb, et;
		longint unsigned ma, mb, mt, sum;
		sa = a[31];
		sb = b[31];
		if (f32_nan(a))
			return a | 32'h0040_0000;
		if (f32_nan(b))
			return b | 32'h0040_0000;
		if (f32_inf(a))
			return (f32_inf(b) && sa != sb) ? FP_DEFAULT_NAN : a;
		if (f32_inf(b))
			return b;
		if (f32_zero(a) && f32_zero(b))
			return {sa & sb, 31'd0};
		if (f32_zero(a))
			return b;
		if (f32_zero(b))
			return a;
		ea = exp_of(a);
		eb = exp_of(b);
		ma = man_of(a);
		mb = man_of(b);
		if (ea < eb || (ea == eb && ma < mb)) begin
			et = ea; ea = eb; eb = et;
			mt = ma; ma = mb; mb = mt;
			st = sa; sa = sb; sb = st;
		end
		ma = ma << 39;
		mb = sticky_shr(mb << 39, ea - eb);
		sum = (sa == sb) ? ma + mb : ma - mb;
		if (sum == 0)
			return 32'd0;
		return pack_rounded(sa, ea, sum);
	endfunction

	// Scoreboard: keeps the right matrix and the queue of expected product rows.
	class product_scoreboard;
		bit [31:0] right_mat [16];
		prod_row_t rows_due [$];
		int        mismatches;

		function void report(string what);
			$display("%0t: mismatch: %s", $realtime, what);
			mismatches++;
		endfunction

		function void note_input(logic kind, logic [1:0] row, logic [31:0] a [4]);
			prod_row_t p;
			bit [31:0] acc;
			if (kind == REQ_LOAD) begin
				for (int k = 0; k < 4; k++)
					right_mat[row * 4 + k] = a[k];
				return;
			end
			p.row = row;
			for (int j = 0; j < 4; j++) begin
				acc = f32_mul(a[0], right_mat[j]);
				for (int k = 1; k < 4; k++)
					acc = f32_add(acc, f32_mul(a[k], right_mat[k * 4 + j]));
				p.col[j] = acc;
			end
			rows_due.push_back(p);
		endfunction

		function void check_result(logic [1:0] row, logic [31:0] c [4]);
			prod_row_t p;
			if (rows_due.size() == 0) begin
				report($sformatf("unexpected product row %0d", row));
				return;
			end
			p = rows_due.pop_front();
			if (row !== p.row)
				report($sformatf("out_row %0d, expected %0d", row, p.row));
			for (int j = 0; j < 4; j++)
				if (c[j] !== p.col[j])
					report($sformatf("row %0d col %0d: %h, expected %h", p.row, j, c[j],
						p.col[j]));
		endfunction
	endclass

	product_scoreboard sb;
	bit loaded [4];

	matrix4x4_float_multiply i_dut (.*);

	// Clock with a 4 ns period.
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Long receiver hold-off, counted down here.
	always @(posedge clk)
		if (hold_left > 0)
			hold_left <= hold_left - 1;

	// Receiver: check each accepted transaction, then choose the next ready.
	always @(posedge clk) begin
		logic [31:0] c [4];
		if (arst_n && out_valid && out_ready) begin
			c = '{out0, out1, out2, out3};
			sb.check_result(out_row, c);
		end
		out_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
	end

	// Offer one transaction and wait for it to be accepted; called at a rising edge.
	task automatic send_item(logic kind, logic [1:0] row, logic [31:0] a [4],
			int unsigned idle_pct);
		in_valid  <= 1'b1;
		req_type  <= kind;
		row_index <= row;
		elem0 <= a[0];
		elem1 <= a[1];
		elem2 <= a[2];
		elem3 <= a[3];
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_input(kind, row, a);
		if (kind == REQ_LOAD)
			loaded[row] = 1'b1;
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4))
				@(posedge clk);
		end
	endtask

	// Random element, weighted toward exponents that interact under addition.
	function automatic logic [31:0] rand_elem();
		logic [31:0] specials [10];
		specials = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
			32'h7F80_0001, 32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF, 32'h3F80_0000};
		case ($urandom_range(9))
			0, 1: return $urandom;
			2: return specials[$urandom_range(9)];
			3: return {1'($urandom), 8'($urandom_range(3)), 23'($urandom)};
			default: return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
		endcase
	endfunction

	task automatic send_random(int unsigned count, int unsigned idle_pct);
		logic [31:0] a [4];
		logic kind;
		logic [1:0] row;
		for (int i = 0; i < count; i++) begin
			foreach (a[k])
				a[k] = rand_elem();
			row = 2'($urandom);
			kind = ($urandom_range(99) < 30) ? REQ_LOAD : REQ_MUL;
			if (!loaded[row])
				kind = REQ_LOAD;
			send_item(kind, row, a, idle_pct);
		end
	endtask

	task automatic wait_drained();
		while (sb.rows_due.size() != 0)
			@(posedge clk);
	endtask

	// Stimulus: directed cases, then random phases with different idling.
	initial begin
		logic [31:0] dir [18][6];
		sb = new();
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		req_type  <= REQ_LOAD;
		row_index <= 2'd0;
		elem0 <= '0;
		elem1 <= '0;
		elem2 <= '0;
		elem3 <= '0;
		stall_pct = 0;
		hold_left = 0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Kind, row, four elements: infinities, NaNs, zeros, subnormals, overflow.
		dir = '{
			'{REQ_LOAD, 0, 32'h3F80_0000, 32'h7F80_0000, 32'h7FA0_0000, 32'h7F7F_FFFF},
			'{REQ_LOAD, 1, 32'h3F80_0000, 32'hFF80_0000, 32'h0000_0000, 32'h7F7F_FFFF},
			'{REQ_LOAD, 2, 32'hBF80_0000, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001},
			'{REQ_LOAD, 3, 32'h0080_0000, 32'h8000_0000, 32'h3F80_0000, 32'h0000_0003},
			'{REQ_MUL, 0, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000},
			'{REQ_MUL, 1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
			'{REQ_MUL, 2, 32'h7F80_0001, 32'hFFFF_FFFF, 32'h3F80_0000, 32'h3F80_0000},
			'{REQ_MUL, 3, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h0000_0000, 32'h0000_0000},
			'{REQ_MUL, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
			'{REQ_MUL, 1, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
			'{REQ_MUL, 2, 32'h0000_0001, 32'h807F_FFFF, 32'h3F00_0000, 32'h0080_0000},
			'{REQ_LOAD, 0, 32'h3F80_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
			'{REQ_LOAD, 1, 32'h0000_0000, 32'h3F80_0000, 32'h0000_0000, 32'h0000_0000},
			'{REQ_LOAD, 2, 32'h8000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h0000_0000},
			'{REQ_LOAD, 3, 32'hBF80_0000, 32'h0000_0000, 32'h0000_0000, 32'h3F80_0000},
			'{REQ_MUL, 3, 32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 32'h3F80_0000},
			'{REQ_MUL, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
			'{REQ_MUL, 1, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF}
		};
		foreach (dir[i])
			send_item(dir[i][0][0], dir[i][1][1:0], '{dir[i][2], dir[i][3], dir[i][4],
				dir[i][5]}, 0);

		// No idling, with a long receiver hold-off so the pipeline fills up.
		hold_left = 60;
		send_random(95, 0);

		// Sender idle most of the time.
		send_random(95, 66);

		// Sender pauses until every product row has come, then the receiver stalls.
		in_valid <= 1'b0;
		wait_drained();
		stall_pct = 66;
		send_random(95, 0);

		// Both sides idle now and then.
		stall_pct = 17;
		send_random(95, 17);

		in_valid <= 1'b0;
		wait_drained();
		repeat (20)
			@(posedge clk);
		if (sb.rows_due.size() != 0)
			sb.report("product rows never arrived");
		if (sb.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Timeout for a hung handshake.
	initial begin
		#400000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: files.f
+incdir+src
src/mx4_pkg.sv
src/mx4_fmul.sv
src/mx4_fadd.sv
src/mx4_round.sv
src/mx4_lane.sv
src/matrix4x4_float_multiply.sv
dv/tb.sv
